// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the point query block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define NCPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ncpq assertion failed");

// Check that a condition implies another in the same cycle.
`define NCPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `NCPQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/core/ncpq_pkg.sv =====
// Package for the navmesh cell point query: widths, edge codes, stage types.
// No dependencies.
package ncpq_pkg;

  localparam int CoordW = 24;
  localparam int IdxW   = 16;
  localparam int NbrW   = 3 * IdxW;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int NormW  = ProdW + 1;
  localparam int SplitW = DiffW + 1;
  localparam int LoPW   = SplitW + 1 + DiffW;
  localparam int HiPW   = (NormW - SplitW) + DiffW;
  localparam int NumW   = NormW + DiffW + 1;
  localparam int MagW   = NumW + 2;
  localparam int QuotW  = CoordW + 2;
  localparam int HW     = QuotW + 4;

  localparam logic [1:0] EdgeAb = 2'd0;
  localparam logic [1:0] EdgeBc = 2'd1;
  localparam logic [1:0] EdgeCa = 2'd2;

  localparam logic [IdxW-1:0] NbrNone = {IdxW{1'b1}};

  localparam logic signed [CoordW-1:0] HMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] HMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CoordW-1:0] vx;
    logic [2:0][CoordW-1:0] vy;
    logic [2:0][CoordW-1:0] vz;
    logic [NbrW-1:0]        nbr;
    logic [CoordW-1:0]      qx;
    logic [CoordW-1:0]      qz;
  } item_t;

  typedef struct packed {
    logic              in_tri;
    logic [1:0]        exit_edge;
    logic [IdxW-1:0]   nbr;
    logic [CoordW-1:0] ay;
  } meta_t;

  typedef struct packed {
    logic            valid;
    meta_t           meta;
    logic [NumW-1:0] num;
    logic [NormW-1:0] ny;
  } front_t;

endpackage

// ===== rtl/core/ncpq_front.sv =====
// Front pipeline: differences, products, edge tests, plane normal, numerator.
// Depends on ncpq_pkg.
module ncpq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  ncpq_pkg::item_t item_i,
  output ncpq_pkg::front_t front_o
);

  localparam int DiffW = ncpq_pkg::DiffW;
  localparam int ProdW = ncpq_pkg::ProdW;
  localparam int NormW = ncpq_pkg::NormW;

  // stage 1: differences
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [DiffW-1:0] lx_d [3], lz_d [3], dx_d [3], dz_d [3];
  logic signed [DiffW-1:0] lx_q [3], lz_q [3], dx_q [3], dz_q [3];
  logic signed [DiffW-1:0] ux_d, uy_d, uz_d, wx_d, wy_d, wz_d;
  logic signed [DiffW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic [ncpq_pkg::CoordW-1:0] ay1_q, ay2_q;
  logic [ncpq_pkg::NbrW-1:0]   nbr1_q, nbr2_q;

  function automatic logic signed [DiffW-1:0] dif(logic [ncpq_pkg::CoordW-1:0] a,
                                                  logic [ncpq_pkg::CoordW-1:0] b);
    dif = DiffW'($signed(a)) - DiffW'($signed(b));
  endfunction

  always_comb begin
    int j;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      lx_d[i] = dif(item_i.vx[j], item_i.vx[i]);
      lz_d[i] = dif(item_i.vz[j], item_i.vz[i]);
      dx_d[i] = dif(item_i.qx, item_i.vx[i]);
      dz_d[i] = dif(item_i.qz, item_i.vz[i]);
    end
    ux_d = dif(item_i.vx[0], item_i.vx[1]);
    uy_d = dif(item_i.vy[0], item_i.vy[1]);
    uz_d = dif(item_i.vz[0], item_i.vz[1]);
    wx_d = dif(item_i.vx[0], item_i.vx[2]);
    wy_d = dif(item_i.vy[0], item_i.vy[2]);
    wz_d = dif(item_i.vz[0], item_i.vz[2]);
  end

  always_ff @(posedge clk_i) begin
    lx_q <= lx_d;
    lz_q <= lz_d;
    dx_q <= dx_d;
    dz_q <= dz_d;
    ux_q <= ux_d;
    uy_q <= uy_d;
    uz_q <= uz_d;
    wx_q <= wx_d;
    wy_q <= wy_d;
    wz_q <= wz_d;
    ay1_q  <= item_i.vy[0];
    nbr1_q <= item_i.nbr;
  end

  // stage 2: products
  logic signed [ProdW-1:0] ep1_q [3], ep2_q [3];
  logic signed [ProdW-1:0] uyvz_q, uzvy_q, uzvx_q, uxvz_q, uxvy_q, uyvx_q;
  logic signed [DiffW-1:0] dqx2_q, dqz2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ep1_q[i] <= lz_q[i] * dx_q[i];
      ep2_q[i] <= lx_q[i] * dz_q[i];
    end
    uyvz_q <= uy_q * wz_q;
    uzvy_q <= uz_q * wy_q;
    uzvx_q <= uz_q * wx_q;
    uxvz_q <= ux_q * wz_q;
    uxvy_q <= ux_q * wy_q;
    uyvx_q <= uy_q * wx_q;
    dqx2_q <= dx_q[0];
    dqz2_q <= dz_q[0];
    ay2_q  <= ay1_q;
    nbr2_q <= nbr1_q;
  end

  // stage 3: edge decisions and normal
  logic signed [NormW-1:0] dot [3];
  logic [2:0]              outside;
  ncpq_pkg::meta_t         meta3_d, meta3_q, meta4_q;
  logic signed [NormW-1:0] nx3_q, ny3_q, nz3_q, ny4_q;
  logic signed [DiffW-1:0] dqx3_q, dqz3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i]     = NormW'(ep2_q[i]) - NormW'(ep1_q[i]);
      outside[i] = !dot[i][NormW-1] && (dot[i] != '0);
    end
    meta3_d.ay = ay2_q;
    if (outside[0]) begin
      meta3_d.in_tri    = 1'b0;
      meta3_d.exit_edge = ncpq_pkg::EdgeAb;
      meta3_d.nbr       = nbr2_q[0 +: ncpq_pkg::IdxW];
    end else if (outside[1]) begin
      meta3_d.in_tri    = 1'b0;
      meta3_d.exit_edge = ncpq_pkg::EdgeBc;
      meta3_d.nbr       = nbr2_q[ncpq_pkg::IdxW +: ncpq_pkg::IdxW];
    end else if (outside[2]) begin
      meta3_d.in_tri    = 1'b0;
      meta3_d.exit_edge = ncpq_pkg::EdgeCa;
      meta3_d.nbr       = nbr2_q[2*ncpq_pkg::IdxW +: ncpq_pkg::IdxW];
    end else begin
      meta3_d.in_tri    = 1'b1;
      meta3_d.exit_edge = ncpq_pkg::EdgeAb;
      meta3_d.nbr       = ncpq_pkg::NbrNone;
    end
  end

  always_ff @(posedge clk_i) begin
    meta3_q <= meta3_d;
    nx3_q   <= NormW'(uyvz_q) - NormW'(uzvy_q);
    ny3_q   <= NormW'(uzvx_q) - NormW'(uxvz_q);
    nz3_q   <= NormW'(uxvy_q) - NormW'(uyvx_q);
    dqx3_q  <= dqx2_q;
    dqz3_q  <= dqz2_q;
  end

  // stage 4: split products of the normal with the query offset
  logic signed [ncpq_pkg::LoPW-1:0] pxl_q, pzl_q;
  logic signed [ncpq_pkg::HiPW-1:0] pxh_q, pzh_q;

  always_ff @(posedge clk_i) begin
    pxl_q   <= $signed({1'b0, nx3_q[ncpq_pkg::SplitW-1:0]}) * dqx3_q;
    pzl_q   <= $signed({1'b0, nz3_q[ncpq_pkg::SplitW-1:0]}) * dqz3_q;
    pxh_q   <= $signed(nx3_q[NormW-1:ncpq_pkg::SplitW]) * dqx3_q;
    pzh_q   <= $signed(nz3_q[NormW-1:ncpq_pkg::SplitW]) * dqz3_q;
    ny4_q   <= ny3_q;
    meta4_q <= meta3_q;
  end

  // stage 5: recombine into the numerator
  logic signed [ncpq_pkg::NumW-1:0] num_d, num_q;
  ncpq_pkg::meta_t meta5_q;
  logic signed [NormW-1:0] ny5_q;

  assign num_d = (ncpq_pkg::NumW'(pxh_q) <<< ncpq_pkg::SplitW) + ncpq_pkg::NumW'(pxl_q)
               + (ncpq_pkg::NumW'(pzh_q) <<< ncpq_pkg::SplitW) + ncpq_pkg::NumW'(pzl_q);

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    ny5_q   <= ny4_q;
    meta5_q <= meta4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign front_o.valid = v5_q;
  assign front_o.meta  = meta5_q;
  assign front_o.num   = num_q;
  assign front_o.ny    = ny5_q;

endmodule

// ===== rtl/core/ncpq_div.sv =====
// Rounding divider pipeline, one quotient bit per stage, and height saturation.
// Depends on ncpq_pkg.
module ncpq_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ncpq_pkg::front_t                   front_i,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic [1:0]                         exit_edge_o,
  output logic signed [ncpq_pkg::IdxW-1:0]   neighbor_index_o,
  output logic signed [ncpq_pkg::CoordW-1:0] plane_height_o,
  output logic                               height_invalid_o
);

  localparam int MagW  = ncpq_pkg::MagW;
  localparam int QuotW = ncpq_pkg::QuotW;
  localparam int HW    = ncpq_pkg::HW;

  typedef struct packed {
    ncpq_pkg::meta_t  meta;
    logic             neg;
    logic             nyz;
    logic             ovf;
    logic [MagW-1:0]  rem;
    logic [MagW-1:0]  dd;
    logic [QuotW-1:0] quo;
  } dstage_t;

  logic [QuotW:0] vld_q;
  dstage_t        st_d [QuotW+1];
  dstage_t        st_q [QuotW+1];

  // set up magnitudes, rounding offset and overflow check
  logic [MagW-1:0] nm, dm, nn;
  always_comb begin
    nm = front_i.num[ncpq_pkg::NumW-1] ? MagW'(-$signed(front_i.num))
                                       : MagW'(front_i.num);
    dm = front_i.ny[ncpq_pkg::NormW-1] ? MagW'(-$signed(front_i.ny))
                                       : MagW'(front_i.ny);
    nn = (nm << 1) + dm;
    st_d[0].meta = front_i.meta;
    st_d[0].neg  = front_i.num[ncpq_pkg::NumW-1] ^ front_i.ny[ncpq_pkg::NormW-1];
    st_d[0].nyz  = (front_i.ny == '0);
    st_d[0].rem  = nn;
    st_d[0].dd   = dm << 1;
    st_d[0].ovf  = nn >= ((dm << 1) << QuotW);
    st_d[0].quo  = '0;
    // one restoring step per stage, most significant bit first
    for (int s = 0; s < QuotW; s++) begin
      st_d[s+1] = st_q[s];
      if (st_q[s].rem >= (st_q[s].dd << (QuotW - 1 - s))) begin
        st_d[s+1].rem = st_q[s].rem - (st_q[s].dd << (QuotW - 1 - s));
        st_d[s+1].quo[QuotW-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= QuotW; s++) begin
      st_q[s] <= st_d[s];
    end
  end

  // final: apply sign, subtract from vertex A height, saturate, flag a zero ny
  dstage_t fin;
  logic [QuotW:0]        qmag;
  logic signed [HW-1:0]  qs, hfull;
  logic signed [ncpq_pkg::CoordW-1:0] h_d;
  logic                  inv_d;

  always_comb begin
    fin   = st_q[QuotW];
    qmag  = fin.ovf ? {1'b1, {QuotW{1'b0}}} : {1'b0, fin.quo};
    qs    = fin.neg ? -HW'(qmag) : HW'(qmag);
    hfull = HW'($signed(fin.meta.ay)) - qs;
    inv_d = 1'b0;
    h_d   = hfull[ncpq_pkg::CoordW-1:0];
    if (fin.nyz) begin
      inv_d = 1'b1;
      h_d   = '0;
    end else if (hfull > HW'(ncpq_pkg::HMax)) begin
      inv_d = 1'b1;
      h_d   = ncpq_pkg::HMax;
    end else if (hfull < HW'(ncpq_pkg::HMin)) begin
      inv_d = 1'b1;
      h_d   = ncpq_pkg::HMin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[QuotW]) begin
      inside_res_o     <= fin.meta.in_tri;
      exit_edge_o      <= fin.meta.exit_edge;
      neighbor_index_o <= $signed(fin.meta.nbr);
      plane_height_o   <= h_d;
      height_invalid_o <= inv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QuotW-1:0], front_i.valid};
      done_o <= vld_q[QuotW];
    end
  end

endmodule

// ===== rtl/core/navmesh_cell_point_query.sv =====
// Top level of the navmesh cell point query: point-in-triangle and plane height.
// Depends on ncpq_pkg, ncpq_front and ncpq_div.
//
// Usage:
//   Drive one triangle, its packed edge neighbors and a query (x, z) with
//   start_i high. A transaction is taken at every rising edge where start_i
//   is high and busy_o is low; busy_o stays low, so a new query may enter in
//   every cycle (one transaction per cycle sustained).
//   Each result is valid for exactly one cycle while done_o is high, in the
//   order of entry. It passes through five arithmetic stages (differences,
//   25x25 products, edge tests and normal, split normal-times-offset
//   products, numerator), one setup stage for the rounding division, 26
//   restoring divider stages that produce one quotient bit each, and the
//   output register.
//   The receiver cannot stall, so the pipeline never holds: every stage
//   advances each cycle and valid bits travel with the data.
//   Reset clears all valid bits at once; payload registers are left as is,
//   and done_o stays low until the first transaction has worked through.
module navmesh_cell_point_query (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_a_x_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_a_y_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_a_z_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_b_x_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_b_y_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_b_z_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_c_x_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_c_y_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] vert_c_z_i,
  input  logic [ncpq_pkg::NbrW-1:0]          edge_neighbors_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] query_x_i,
  input  logic signed [ncpq_pkg::CoordW-1:0] query_z_i,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic [1:0]                         exit_edge_o,
  output logic signed [ncpq_pkg::IdxW-1:0]   neighbor_index_o,
  output logic signed [ncpq_pkg::CoordW-1:0] plane_height_o,
  output logic                               height_invalid_o
);

  ncpq_pkg::item_t  item;
  ncpq_pkg::front_t front;
  logic             accept;

  // The pipeline never stalls, so it is never busy.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Pack the vertex ports, index 0 for A, 1 for B, 2 for C.
  assign item.vx  = {vert_c_x_i, vert_b_x_i, vert_a_x_i};
  assign item.vy  = {vert_c_y_i, vert_b_y_i, vert_a_y_i};
  assign item.vz  = {vert_c_z_i, vert_b_z_i, vert_a_z_i};
  assign item.nbr = edge_neighbors_i;
  assign item.qx  = query_x_i;
  assign item.qz  = query_z_i;

  ncpq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item),
    .front_o (front)
  );

  ncpq_div u_div (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .front_i          (front),
    .done_o           (done_o),
    .inside_res_o     (inside_res_o),
    .exit_edge_o      (exit_edge_o),
    .neighbor_index_o (neighbor_index_o),
    .plane_height_o   (plane_height_o),
    .height_invalid_o (height_invalid_o)
  );

endmodule

// ===== rtl/core/ncpq_checker.sv =====
// Port-level checker for navmesh_cell_point_query, attached by bind.
// Depends on ncpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ncpq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               busy_o,
  input logic                               done_o,
  input logic                               inside_res_o,
  input logic [1:0]                         exit_edge_o,
  input logic signed [ncpq_pkg::IdxW-1:0]   neighbor_index_o,
  input logic signed [ncpq_pkg::CoordW-1:0] plane_height_o,
  input logic                               height_invalid_o
);

  // A fully pipelined block never refuses a transaction.
  `NCPQ_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o)

  `NCPQ_ASSERT_IMP(a_inside_no_exit, clk_i, rst_ni, done_o && inside_res_o,
    exit_edge_o == ncpq_pkg::EdgeAb && neighbor_index_o == $signed(ncpq_pkg::NbrNone))

  `NCPQ_ASSERT_IMP(a_edge_code, clk_i, rst_ni, done_o,
    exit_edge_o == ncpq_pkg::EdgeAb || exit_edge_o == ncpq_pkg::EdgeBc
    || exit_edge_o == ncpq_pkg::EdgeCa)

  // An invalid nonzero height must sit on a saturation bound.
  `NCPQ_ASSERT_IMP(a_invalid_saturated, clk_i, rst_ni,
    done_o && height_invalid_o && plane_height_o != '0,
    plane_height_o == ncpq_pkg::HMax || plane_height_o == ncpq_pkg::HMin)

endmodule

bind navmesh_cell_point_query ncpq_checker u_ncpq_checker (.*);
